[sv/hsfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfd_pkg: shared types and constants for the sensor frame decoder
// Byte positions, status codes, controller states, command and status
// structs, conversion constants and the CRC-8 byte update function.
// ----------------------------------------------------------------------------
package hsfd_pkg;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int OFFS_W   = 12;
    localparam int CEL_W    = 15;
    localparam int FAH_W    = 16;
    localparam int HUM_W    = 14;
    localparam int RAW_W    = 16;
    localparam int POS_W    = 3;

    // Byte positions inside one six-byte frame.
    localparam logic [POS_W-1:0] POS_T_HI  = 3'd0;
    localparam logic [POS_W-1:0] POS_T_LO  = 3'd1;
    localparam logic [POS_W-1:0] POS_T_CRC = 3'd2;
    localparam logic [POS_W-1:0] POS_H_HI  = 3'd3;
    localparam logic [POS_W-1:0] POS_H_LO  = 3'd4;
    localparam logic [POS_W-1:0] POS_H_CRC = 3'd5;

    // CRC-8 parameters.
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

    // Conversion constants.
    localparam int T_PROD_W = 31;   // 17500 * 65535 fits in 31 bits
    localparam int H_PROD_W = 30;   // 10000 * 65535 fits in 30 bits
    localparam logic [14:0] TEMP_SCALE = 15'd17500;
    localparam logic [13:0] HUM_SCALE  = 14'd10000;
    localparam logic [16:0] FULL_SCALE = 17'd65535;
    localparam logic signed [15:0] TEMP_BASE = -16'sd4500;
    localparam logic [FAH_W-1:0] FAH_BASE = 16'd3200;

    // Division by five: floor(n / 5) = (n * 209716) >> 20, exact for n < 2^18.
    // Nine times the Celsius value stays below 2^18 in magnitude.
    localparam int MAG_W       = 18;
    localparam int RECIP_W     = 18;
    localparam int FPROD_W     = 35;   // 135423 * 209716 fits in 35 bits
    localparam int DIV5_SHIFT  = 20;
    localparam logic [RECIP_W-1:0] DIV5_RECIP = 18'd209716;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TEMP_CRC = 2'd1,
        ST_HUM_CRC  = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_CEL,
        S_FMUL,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic mul_en;
        logic div_en;
        logic cel_en;
        logic fmul_en;
        logic load_out;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_byte;
        logic out_free;
    } t_dp_status;

    // One byte through the CRC-8 register, MSB first.
    function automatic logic [BYTE_W-1:0] crc_feed(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[sv/hsfd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfd_ctrl: frame decoder controller
// Takes bytes while idle and, after the last byte of a frame, steps the
// datapath through the conversion and the load of the output register.
// ----------------------------------------------------------------------------
module hsfd_ctrl
    import hsfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_dp_status i_st,
    output t_ctrl_cmd  o_cmd,
    output logic       o_stall
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_st.last_byte) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_en = 1'b1;
                n_state      = S_CEL;
            end
            S_CEL: begin
                o_cmd.cel_en = 1'b1;
                n_state      = S_FMUL;
            end
            S_FMUL: begin
                o_cmd.fmul_en = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                // Wait here until the output register can take the word.
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/hsfd_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfd_dp: frame decoder datapath
// Byte position, running CRC, raw word capture, the fixed-point conversion
// steps and the output register.
// ----------------------------------------------------------------------------
module hsfd_dp
    import hsfd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctrl_cmd               i_cmd,
    input  logic [BYTE_W-1:0]       i_byte_value,
    input  logic                    i_frame_start,
    input  logic                    i_cfg_we,
    input  logic [OFFS_W-1:0]       i_cfg_wdata,
    input  logic                    i_out_stall,
    output t_dp_status              o_st,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic signed [CEL_W-1:0] o_temp_centi_c,
    output logic signed [FAH_W-1:0] o_temp_centi_f,
    output logic [HUM_W-1:0]        o_humidity_centi_pct
);

    // Control state.
    logic [POS_W-1:0]    r_pos;
    logic [BYTE_W-1:0]   r_crc;
    logic                r_temp_good;
    logic [OFFS_W-1:0]   r_offset;
    logic                r_out_valid;

    // Payload registers.
    logic [BYTE_W-1:0]   r_t_hi;
    logic [BYTE_W-1:0]   r_t_lo;
    logic [BYTE_W-1:0]   r_h_hi;
    logic [BYTE_W-1:0]   r_h_lo;
    t_status             r_status;
    logic [T_PROD_W-1:0] r_prod_t;
    logic [H_PROD_W-1:0] r_prod_h;
    logic [CEL_W-1:0]    r_qt;
    logic [HUM_W-1:0]    r_h;
    logic [CEL_W-1:0]    r_c;
    logic [FPROD_W-1:0]  r_fprod;
    logic                r_fneg;
    t_status             r_o_status;
    logic [CEL_W-1:0]    r_o_c;
    logic [FAH_W-1:0]    r_o_f;
    logic [HUM_W-1:0]    r_o_h;

    // Byte handling signals.
    logic [POS_W-1:0]    pos;
    logic [BYTE_W-1:0]   crc_base;
    logic [BYTE_W-1:0]   crc_upd;
    logic [POS_W-1:0]    n_pos;
    logic [BYTE_W-1:0]   n_crc;
    logic                n_temp_good;
    t_status             n_status;

    // Conversion signals.
    logic [16:0]         sum_t;
    logic [16:0]         sum_h;
    logic signed [15:0]  c_wide;
    logic signed [18:0]  c19;
    logic signed [18:0]  c9;
    logic [18:0]         c9_mag;
    logic [CEL_W-1:0]    fq;
    logic [FAH_W-1:0]    f_val;

    // Position of the incoming byte; a start marker or a stray count restarts.
    always_comb begin
        if (i_frame_start || (r_pos > POS_H_CRC)) begin
            pos = POS_T_HI;
        end else begin
            pos = r_pos;
        end
        crc_base   = (pos == POS_T_HI) ? CRC_INIT : r_crc;
        crc_upd    = crc_feed(crc_base, i_byte_value);
        o_st.last_byte = (pos == POS_H_CRC);
        o_st.out_free  = !r_out_valid || !i_out_stall;
    end

    // Next byte-handling state for one accepted word.
    always_comb begin
        n_pos       = pos + 3'd1;
        n_crc       = crc_upd;
        n_temp_good = r_temp_good;
        n_status    = ST_OK;
        unique case (pos)
            POS_T_CRC: begin
                n_temp_good = (r_crc == i_byte_value);
                n_crc       = CRC_INIT;
            end
            POS_H_CRC: begin
                n_pos = POS_T_HI;
                n_crc = CRC_INIT;
                if (!r_temp_good) begin
                    n_status = ST_TEMP_CRC;
                end else if (r_crc != i_byte_value) begin
                    n_status = ST_HUM_CRC;
                end
            end
            default: begin
            end
        endcase
    end

    // Byte position, CRC and the CRC flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_T_HI;
            r_crc       <= CRC_INIT;
            r_temp_good <= 1'b0;
        end else if (i_cmd.accept) begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_temp_good <= n_temp_good;
        end
    end

    // Raw data bytes and frame status.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            case (pos)
                POS_T_HI:  r_t_hi   <= i_byte_value;
                POS_T_LO:  r_t_lo   <= i_byte_value;
                POS_H_HI:  r_h_hi   <= i_byte_value;
                POS_H_LO:  r_h_lo   <= i_byte_value;
                POS_H_CRC: r_status <= n_status;
                default: begin
                end
            endcase
        end
    end

    // Offset register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg_we) begin
            r_offset <= i_cfg_wdata;
        end
    end

    // Division by 65535: x = a*65536 + b gives a + (a + b >= 65535).
    assign sum_t = {2'b00, r_prod_t[T_PROD_W-1:16]} + {1'b0, r_prod_t[15:0]};
    assign sum_h = {3'b000, r_prod_h[H_PROD_W-1:16]} + {1'b0, r_prod_h[15:0]};

    // Celsius with offset, then nine times it and its magnitude.
    assign c_wide = TEMP_BASE + $signed({1'b0, r_qt})
                  + $signed({{(16-OFFS_W){r_offset[OFFS_W-1]}}, r_offset});
    assign c19    = $signed({{(19-CEL_W){r_c[CEL_W-1]}}, r_c});
    assign c9     = (c19 <<< 3) + c19;
    assign c9_mag = c9[18] ? 19'(-c9) : 19'(c9);

    // Fahrenheit from the truncated quotient.
    assign fq    = r_fprod[FPROD_W-1:DIV5_SHIFT];
    assign f_val = r_fneg ? (FAH_BASE - {1'b0, fq}) : (FAH_BASE + {1'b0, fq});

    // Conversion steps, one per controller state.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod_t <= T_PROD_W'({r_t_hi, r_t_lo}) * T_PROD_W'(TEMP_SCALE);
            r_prod_h <= H_PROD_W'({r_h_hi, r_h_lo}) * H_PROD_W'(HUM_SCALE);
        end
        if (i_cmd.div_en) begin
            r_qt <= r_prod_t[T_PROD_W-1:16] + CEL_W'(sum_t >= FULL_SCALE);
            r_h  <= r_prod_h[H_PROD_W-1:16] + HUM_W'(sum_h >= FULL_SCALE);
        end
        if (i_cmd.cel_en) begin
            r_c <= c_wide[CEL_W-1:0];
        end
        if (i_cmd.fmul_en) begin
            r_fprod <= FPROD_W'(c9_mag[MAG_W-1:0]) * FPROD_W'(DIV5_RECIP);
            r_fneg  <= c9[18];
        end
    end

    // Output register; a bad frame reports zero values.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_status <= r_status;
            if (r_status == ST_OK) begin
                r_o_c <= r_c;
                r_o_f <= f_val;
                r_o_h <= r_h;
            end else begin
                r_o_c <= '0;
                r_o_f <= '0;
                r_o_h <= '0;
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_status             = r_o_status;
    assign o_temp_centi_c       = $signed(r_o_c);
    assign o_temp_centi_f       = $signed(r_o_f);
    assign o_humidity_centi_pct = r_o_h;

endmodule

[sv/humidity_sensor_frame_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_core: sensor measurement frame decoder
// Checks and converts six-byte temperature/humidity measurement frames.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one frame byte per word with its
// start marker. Bytes arrive as temperature high, low, CRC, then humidity
// high, low, CRC; a start marker forces the byte to be the first of a frame.
// Output channel: o_valid / i_stall carry one result word per complete frame.
// Configuration: i_cfg_we writes the signed Celsius offset from i_cfg_wdata.
// Flow: the first five bytes of a frame are taken whenever offered. The sixth
// byte starts a four-step conversion (multiply, divide by full scale, offset
// add, multiply by the reciprocal of five), so o_stall is high during those
// steps and during the step that loads the output register.
// Stall: the output register holds the word while i_stall is high; the next
// frame's bytes are still taken, and a following result waits in the final
// step with o_stall high until the register is free.
// Reset: synchronous, active low; the frame position restarts, the CRC is
// set to 0xFF, the offset clears and no result is pending.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_decoder_core
    import hsfd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [BYTE_W-1:0]       i_byte_value,
    input  logic                    i_frame_start,
    input  logic                    i_cfg_we,
    input  logic [OFFS_W-1:0]       i_cfg_wdata,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [1:0]              o_status,
    output logic signed [CEL_W-1:0] o_temp_centi_c,
    output logic signed [FAH_W-1:0] o_temp_centi_f,
    output logic [HUM_W-1:0]        o_humidity_centi_pct
);

    t_ctrl_cmd  cmd;
    t_dp_status st;

    // Controller.
    hsfd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_st    (st),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    // Datapath.
    hsfd_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_byte_value         (i_byte_value),
        .i_frame_start        (i_frame_start),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_out_stall          (i_stall),
        .o_st                 (st),
        .o_valid              (o_valid),
        .o_status             (o_status),
        .o_temp_centi_c       (o_temp_centi_c),
        .o_temp_centi_f       (o_temp_centi_f),
        .o_humidity_centi_pct (o_humidity_centi_pct)
    );

endmodule

[sv/hsfd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfd_checker: port-level checks for the frame decoder
// Watches the output channel and the input stall of the top level.
// ----------------------------------------------------------------------------
module hsfd_checker
    import hsfd_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic [1:0]              o_status,
    input logic signed [CEL_W-1:0] o_temp_centi_c,
    input logic signed [FAH_W-1:0] o_temp_centi_f,
    input logic [HUM_W-1:0]        o_humidity_centi_pct
);

    // A stalled result stays offered.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its status.
    a_status_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_status))
        else $error("result status changed while stalled");

    // A CRC failure reports zero values.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |->
            (o_temp_centi_c == '0) && (o_temp_centi_f == '0)
            && (o_humidity_centi_pct == '0))
        else $error("nonzero values with a CRC failure");

    // A new result is loaded only from the last conversion step.
    a_load_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a conversion step");

    // Humidity never exceeds full scale.
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_humidity_centi_pct <= HUM_W'(10000)))
        else $error("humidity out of range");

endmodule

bind humidity_sensor_frame_decoder_core hsfd_checker u_hsfd_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_stall              (o_stall),
    .o_valid              (o_valid),
    .i_stall              (i_stall),
    .o_status             (o_status),
    .o_temp_centi_c       (o_temp_centi_c),
    .o_temp_centi_f       (o_temp_centi_f),
    .o_humidity_centi_pct (o_humidity_centi_pct)
);

[test/humidity_sensor_frame_decoder_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_core_tb: self-checking bench for the decoder
// A directed set of frames covers the range extremes, both CRC failure kinds,
// a restart in the middle of a frame and a frame that follows on without a
// start marker. Random frames then run under four flow-control patterns,
// each with its own Celsius offset. The bench holds its own integer model
// of the decoder, and a scoreboard compares every result word with it.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_decoder_core_tb;
    import hsfd_pkg::*;

    // One decoded reading as the output channel carries it.
    typedef struct {
        t_status           status;
        logic [CEL_W-1:0]  cel;
        logic [FAH_W-1:0]  fah;
        logic [HUM_W-1:0]  hum;
    } t_reading;

    // Tracks the frame state the decoder should hold and the readings it owes.
    class reading_scoreboard;
        logic [POS_W-1:0]  next_pos;
        logic [BYTE_W-1:0] crc_acc;
        logic [RAW_W-1:0]  temp_word;
        bit                temp_ok;
        logic [BYTE_W-1:0] hum_hi;
        logic [BYTE_W-1:0] hum_lo;
        int                cel_offset;
        t_reading          owed_readings[$];
        int                n_errors;
        int                n_checked;
        int                n_ok;
        int                n_temp_bad;
        int                n_hum_bad;

        function new();
            next_pos   = POS_T_HI;
            crc_acc    = CRC_INIT;
            temp_word  = '0;
            temp_ok    = 1'b0;
            hum_hi     = '0;
            hum_lo     = '0;
            cel_offset = 0;
            n_errors   = 0;
            n_checked  = 0;
            n_ok       = 0;
            n_temp_bad = 0;
            n_hum_bad  = 0;
        endfunction

        // CRC-8 with polynomial 0x31, most significant bit first.
        static function logic [BYTE_W-1:0] crc_byte(logic [BYTE_W-1:0] crc,
                                                    logic [BYTE_W-1:0] d);
            logic [BYTE_W-1:0] r;
            r = crc ^ d;
            repeat (BYTE_W) begin
                r = r[BYTE_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
            end
            return r;
        endfunction

        static function logic [BYTE_W-1:0] word_crc(logic [RAW_W-1:0] w);
            return crc_byte(crc_byte(CRC_INIT, w[15:8]), w[7:0]);
        endfunction

        function void set_offset(logic [OFFS_W-1:0] v);
            cel_offset = int'($signed(v));
        endfunction

        function int pending();
            return owed_readings.size();
        endfunction

        // Advance the frame state by one accepted byte.
        function void take_byte(logic [BYTE_W-1:0] b, bit start);
            logic [POS_W-1:0] p;
            longint           tc;
            longint           fc;
            longint           hc;
            bit               hum_ok;
            t_reading         r;
            p = next_pos;
            if (start || p > POS_H_CRC) begin
                p = POS_T_HI;
            end
            if (p == POS_T_HI) begin
                crc_acc = CRC_INIT;
            end
            case (p)
                POS_T_HI: begin
                    crc_acc   = crc_byte(crc_acc, b);
                    temp_word = {b, 8'h00};
                end
                POS_T_LO: begin
                    crc_acc        = crc_byte(crc_acc, b);
                    temp_word[7:0] = b;
                end
                POS_T_CRC: begin
                    temp_ok = (crc_acc == b);
                    crc_acc = CRC_INIT;
                end
                POS_H_HI: begin
                    crc_acc = crc_byte(crc_acc, b);
                    hum_hi  = b;
                end
                POS_H_LO: begin
                    crc_acc = crc_byte(crc_acc, b);
                    hum_lo  = b;
                end
                default: begin
                    // Last byte of the frame: a reading is due.
                    hum_ok   = (crc_acc == b);
                    crc_acc  = CRC_INIT;
                    next_pos = POS_T_HI;
                    r.status = ST_OK;
                    r.cel    = '0;
                    r.fah    = '0;
                    r.hum    = '0;
                    if (!temp_ok) begin
                        r.status = ST_TEMP_CRC;
                        n_temp_bad++;
                    end else if (!hum_ok) begin
                        r.status = ST_HUM_CRC;
                        n_hum_bad++;
                    end else begin
                        tc = -4500 + (17500 * longint'(temp_word)) / 65535 + cel_offset;
                        fc = (tc * 9) / 5 + 3200;
                        hc = (10000 * longint'({hum_hi, hum_lo})) / 65535;
                        r.cel = tc[CEL_W-1:0];
                        r.fah = fc[FAH_W-1:0];
                        r.hum = hc[HUM_W-1:0];
                        n_ok++;
                    end
                    owed_readings.push_back(r);
                    return;
                end
            endcase
            next_pos = p + 1'b1;
        endfunction

        // Compare one accepted result word with the oldest owed reading.
        function void check_reading(logic [1:0] st, logic [CEL_W-1:0] c,
                                    logic [FAH_W-1:0] f, logic [HUM_W-1:0] h);
            t_reading e;
            n_checked++;
            if (owed_readings.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("%0t: unexpected result: status %0d C %0d F %0d H %0d",
                             $time, st, $signed(c), $signed(f), h);
                end
                return;
            end
            e = owed_readings.pop_front();
            if (st != e.status || c != e.cel || f != e.fah || h != e.hum) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("%0t: mismatch: expected status %0d C %0d F %0d H %0d,",
                             $time, e.status, $signed(e.cel), $signed(e.fah), e.hum);
                    $display("    got status %0d C %0d F %0d H %0d",
                             st, $signed(c), $signed(f), h);
                end
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [BYTE_W-1:0]       i_byte_value;
    logic                    i_frame_start;
    logic                    i_cfg_we;
    logic [OFFS_W-1:0]       i_cfg_wdata;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [1:0]              o_status;
    logic signed [CEL_W-1:0] o_temp_centi_c;
    logic signed [FAH_W-1:0] o_temp_centi_f;
    logic [HUM_W-1:0]        o_humidity_centi_pct;

    reading_scoreboard sb = new();
    int idle_pct  = 0;
    int stall_pct = 0;
    int bytes_sent = 0;

    humidity_sensor_frame_decoder_core DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_byte_value         (i_byte_value),
        .i_frame_start        (i_frame_start),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_status             (o_status),
        .o_temp_centi_c       (o_temp_centi_c),
        .o_temp_centi_f       (o_temp_centi_f),
        .o_humidity_centi_pct (o_humidity_centi_pct)
    );

    // Clock: 20 ns period.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver back-pressure, changed on the falling edge.
    always @(negedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    // Every result word accepted at a rising edge goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_reading(o_status, o_temp_centi_c, o_temp_centi_f,
                             o_humidity_centi_pct);
        end
    end

    // Offer one byte, with random gaps before it, and wait until it is taken.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit start);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_byte_value  <= b;
        i_frame_start <= start;
        do @(posedge i_clk); while (o_stall);
        sb.take_byte(b, start);
        bytes_sent++;
    endtask

    // Send the first n_bytes of a frame; nonzero err values spoil a CRC.
    task automatic send_frame(input logic [RAW_W-1:0] tw, input logic [RAW_W-1:0] hw,
                              input logic [BYTE_W-1:0] t_err,
                              input logic [BYTE_W-1:0] h_err,
                              input bit start, input int n_bytes);
        logic [BYTE_W-1:0] fb [6];
        fb[0] = tw[15:8];
        fb[1] = tw[7:0];
        fb[2] = reading_scoreboard::word_crc(tw) ^ t_err;
        fb[3] = hw[15:8];
        fb[4] = hw[7:0];
        fb[5] = reading_scoreboard::word_crc(hw) ^ h_err;
        for (int i = 0; i < n_bytes; i++) begin
            send_byte(fb[i], start && i == 0);
        end
    endtask

    function automatic logic [RAW_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_error();
        return ($urandom_range(99) < 8) ? BYTE_W'($urandom_range(255, 1)) : 8'h00;
    endfunction

    // Let the decoder drain, then write the Celsius offset.
    task automatic write_offset(input int v);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v[OFFS_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_offset(v[OFFS_W-1:0]);
    endtask

    // Mostly clean frames, plus cut-off frames and stray bytes.
    task automatic run_traffic(input int n_bytes);
        int stop_at;
        int r;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 75) begin
                send_frame(pick_word(), pick_word(), pick_error(), pick_error(),
                           $urandom_range(4) != 0, 6);
            end else if (r < 90) begin
                send_frame(pick_word(), pick_word(), 8'h00, 8'h00,
                           1'($urandom_range(1)), $urandom_range(5, 1));
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    send_byte(BYTE_W'($urandom), 1'($urandom_range(1)));
                end
            end
        end
    endtask

    initial begin
        int rand_offset;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_byte_value  = '0;
        i_frame_start = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames at zero offset.
        write_offset(0);
        send_frame(16'h0000, 16'h0000, 8'h00, 8'h00, 1'b1, 6);
        // Follows on without a start marker: the position wraps after byte six.
        send_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 1'b0, 6);
        send_frame(16'h6666, 16'h8000, 8'h5A, 8'h00, 1'b1, 6);
        // A start marker drops the partial frame; the new one has a bad humidity CRC.
        send_frame(16'h1234, 16'h4321, 8'h00, 8'h00, 1'b1, 2);
        send_frame(16'h8000, 16'h7FFF, 8'h00, 8'h01, 1'b1, 6);

        // Random traffic: one offset and one flow-control pattern per phase.
        write_offset(-2000);
        idle_pct = 0;  stall_pct = 0;
        run_traffic(375);
        write_offset(2000);
        idle_pct = 46; stall_pct = 0;
        run_traffic(375);
        write_offset(-1);
        idle_pct = 0;  stall_pct = 46;
        run_traffic(375);
        rand_offset = $urandom_range(4000) - 2000;
        write_offset(rand_offset);
        idle_pct = 28; stall_pct = 28;
        run_traffic(375);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d bytes; %0d readings: %0d good, %0d temp CRC, %0d humidity CRC errors.",
                 bytes_sent, sb.n_checked, sb.n_ok, sb.n_temp_bad, sb.n_hum_bad);
        $display("Five offset settings, four flow-control patterns, %0d mismatches.",
                 sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #10ms;
        $display("Timeout with %0d readings still owed.", sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
